### design/mips_rtype_execute_unit_assert.svh
// Assertion macros for the R-type execute unit; empty when synthesizing.
`ifndef MIPS_RTYPE_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_RTYPE_EXECUTE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check an implication or expression on every clock edge outside reset.
`define MRXU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define MRXU_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define MRXU_ASSERT(label, clk, rst, prop, msg)
`define MRXU_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### design/mrexu_pkg.sv
// Types, codes and constants shared by the R-type execute unit.
package mrexu_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned REG_AW     = 5;
  localparam int unsigned REG_DEPTH  = 32;
  localparam int unsigned SHAMT_W    = 5;
  localparam int unsigned FUNCT_W    = 6;
  localparam int unsigned OPCODE_W   = 6;

  // Input kinds
  localparam logic KIND_EXEC = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Function codes of the R-type word
  typedef enum logic [FUNCT_W-1:0] {
    FN_SLL  = 6'd0,
    FN_SRL  = 6'd2,
    FN_SRA  = 6'd3,
    FN_SLLV = 6'd4,
    FN_SRLV = 6'd6,
    FN_SRAV = 6'd7,
    FN_JR   = 6'd8,
    FN_JALR = 6'd9,
    FN_MFHI = 6'd16,
    FN_MTHI = 6'd17,
    FN_MFLO = 6'd18,
    FN_MTLO = 6'd19,
    FN_ADD  = 6'd32,
    FN_ADDU = 6'd33,
    FN_SUB  = 6'd34,
    FN_SUBU = 6'd35,
    FN_AND  = 6'd36,
    FN_OR   = 6'd37,
    FN_XOR  = 6'd38,
    FN_SLT  = 6'd42,
    FN_SLTU = 6'd43
  } funct_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_t;

  localparam logic [XLEN-1:0] LINK_OFFSET = 32'd8;

  typedef struct packed {
    logic              kind;
    logic [XLEN-1:0]   instr_word;
    logic [XLEN-1:0]   pc_value;
    logic [REG_AW-1:0] load_index;
    logic [XLEN-1:0]   load_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              wrote_reg;
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   write_value;
    logic              jump_taken;
    logic [XLEN-1:0]   jump_target;
  } res_t;

  // Execute outcome: the result item plus the state updates it implies
  typedef struct packed {
    res_t item;
    logic reg_we;
    logic hi_we;
    logic lo_we;
  } exec_t;

endpackage

### design/mrexu_regfile.sv
// General register file: synchronous two-read one-write memory with reset valid bits.
module mrexu_regfile (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [mrexu_pkg::REG_AW-1:0] rd_addr_a,
  input  logic [mrexu_pkg::REG_AW-1:0] rd_addr_b,
  output logic [mrexu_pkg::XLEN-1:0]   rd_data_a,
  output logic [mrexu_pkg::XLEN-1:0]   rd_data_b,
  input  logic                         wr_en,
  input  logic [mrexu_pkg::REG_AW-1:0] wr_addr,
  input  logic [mrexu_pkg::XLEN-1:0]   wr_data
);
  import mrexu_pkg::*;

  logic [XLEN-1:0]      mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] valid;

  logic [XLEN-1:0]   q_a, q_b;
  logic              v_a, v_b;
  logic [REG_AW-1:0] addr_a, addr_b;

  // Last write; equals the memory content at its address and covers a read
  // issued at the same edge as that write
  logic              byp_en;
  logic [REG_AW-1:0] byp_addr;
  logic [XLEN-1:0]   byp_data;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a    <= mem[rd_addr_a];
      q_b    <= mem[rd_addr_b];
      addr_a <= rd_addr_a;
      addr_b <= rd_addr_b;
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      v_a   <= 1'b0;
      v_b   <= 1'b0;
    end else begin
      if (rd_en) begin
        v_a <= valid[rd_addr_a];
        v_b <= valid[rd_addr_b];
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  // Capture the latest write for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_en <= 1'b0;
    end else if (wr_en) begin
      byp_en <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_addr <= wr_addr;
      byp_data <= wr_data;
    end
  end

  // Forward the latest write, else the memory word masked by its valid bit
  always_comb begin
    if (byp_en && byp_addr == addr_a) begin
      rd_data_a = byp_data;
    end else begin
      rd_data_a = v_a ? q_a : '0;
    end
    if (byp_en && byp_addr == addr_b) begin
      rd_data_b = byp_data;
    end else begin
      rd_data_b = v_b ? q_b : '0;
    end
  end

endmodule

### design/mrexu_alu.sv
// Decode and execute of one R-type word or direct register load.
module mrexu_alu (
  input  mrexu_pkg::cmd_t            cmd,
  input  logic [mrexu_pkg::XLEN-1:0] a,
  input  logic [mrexu_pkg::XLEN-1:0] b,
  input  logic [mrexu_pkg::XLEN-1:0] hi,
  input  logic [mrexu_pkg::XLEN-1:0] lo,
  output mrexu_pkg::exec_t           exec
);
  import mrexu_pkg::*;

  logic [FUNCT_W-1:0]  funct;
  logic [SHAMT_W-1:0]  shamt;
  logic [SHAMT_W-1:0]  vshamt;
  logic [REG_AW-1:0]   rd;
  logic [OPCODE_W-1:0] opcode;
  logic [XLEN-1:0]     sum, diff;
  logic                add_ovf, sub_ovf;
  logic [XLEN-1:0]     val;
  logic [REG_AW-1:0]   idx;
  logic                do_write;
  logic [1:0]          status;
  logic                jump;
  logic                hi_we, lo_we;

  assign funct  = cmd.instr_word[5:0];
  assign shamt  = cmd.instr_word[10:6];
  assign rd     = cmd.instr_word[15:11];
  assign opcode = cmd.instr_word[31:26];
  assign vshamt = a[SHAMT_W-1:0];

  assign sum     = a + b;
  assign diff    = a - b;
  assign add_ovf = ~(a[XLEN-1] ^ b[XLEN-1]) & (a[XLEN-1] ^ sum[XLEN-1]);
  assign sub_ovf = (a[XLEN-1] ^ b[XLEN-1]) & (a[XLEN-1] ^ diff[XLEN-1]);

  // Decode and compute
  always_comb begin
    val      = '0;
    idx      = rd;
    do_write = 1'b0;
    status   = ST_OK;
    jump     = 1'b0;
    hi_we    = 1'b0;
    lo_we    = 1'b0;
    if (cmd.kind == KIND_LOAD) begin
      idx      = cmd.load_index;
      val      = cmd.load_value;
      do_write = 1'b1;
    end else if (opcode != '0) begin
      status = ST_UNKNOWN;
    end else begin
      unique case (funct)
        FN_ADD: begin
          if (add_ovf) begin
            status = ST_OVERFLOW;
          end else begin
            val      = sum;
            do_write = 1'b1;
          end
        end
        FN_SUB: begin
          if (sub_ovf) begin
            status = ST_OVERFLOW;
          end else begin
            val      = diff;
            do_write = 1'b1;
          end
        end
        FN_ADDU: begin val = sum;  do_write = 1'b1; end
        FN_SUBU: begin val = diff; do_write = 1'b1; end
        FN_AND:  begin val = a & b; do_write = 1'b1; end
        FN_OR:   begin val = a | b; do_write = 1'b1; end
        FN_XOR:  begin val = a ^ b; do_write = 1'b1; end
        FN_SLL:  begin val = b << shamt;  do_write = 1'b1; end
        FN_SRL:  begin val = b >> shamt;  do_write = 1'b1; end
        FN_SRA:  begin val = $unsigned($signed(b) >>> shamt); do_write = 1'b1; end
        FN_SLLV: begin val = b << vshamt; do_write = 1'b1; end
        FN_SRLV: begin val = b >> vshamt; do_write = 1'b1; end
        FN_SRAV: begin val = $unsigned($signed(b) >>> vshamt); do_write = 1'b1; end
        FN_SLT: begin
          val      = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
          do_write = 1'b1;
        end
        FN_SLTU: begin
          val      = {{(XLEN-1){1'b0}}, (a < b)};
          do_write = 1'b1;
        end
        FN_MFHI: begin val = hi; do_write = 1'b1; end
        FN_MFLO: begin val = lo; do_write = 1'b1; end
        FN_MTHI: hi_we = 1'b1;
        FN_MTLO: lo_we = 1'b1;
        FN_JR:   jump = 1'b1;
        FN_JALR: begin
          jump     = 1'b1;
          val      = cmd.pc_value + LINK_OFFSET;
          do_write = 1'b1;
        end
        default: status = ST_UNKNOWN;
      endcase
    end
  end

  // Drop writes to register zero and pack the result
  always_comb begin
    exec.hi_we            = hi_we;
    exec.lo_we            = lo_we;
    exec.reg_we           = do_write && (idx != '0);
    exec.item.status      = status;
    exec.item.wrote_reg   = exec.reg_we;
    exec.item.dest_index  = exec.reg_we ? idx : '0;
    exec.item.write_value = exec.reg_we ? val : '0;
    exec.item.jump_taken  = jump;
    exec.item.jump_target = jump ? a : '0;
  end

endmodule

### design/mips_rtype_execute_unit.sv
// R-type execute unit: a command is taken at most every cycle and its result
// passes through the execute stage into the result register. Operands are read
// from the register file memory at the transfer edge and come out registered in
// the execute stage, where the ALU result is written back; a write landing at
// the same edge as a read is forwarded from the last-write register, so
// dependent commands can follow back to back. HI and LO sit in flip-flops.
// Sustained rate is one command per cycle, limited only by stall on the result
// side; an execute stage and a result register decouple the two channels.
module mips_rtype_execute_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  mrexu_pkg::cmd_t   cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output mrexu_pkg::res_t   res
);
  import mrexu_pkg::*;

`include "mips_rtype_execute_unit_assert.svh"

  logic            cmd_xfer;
  logic            ex_valid;
  cmd_t            ex_cmd;
  logic            ex_adv;
  logic [XLEN-1:0] op_a, op_b;
  logic [XLEN-1:0] hi_reg, lo_reg;
  exec_t           exec;

  // Handshake: execute stage moves on unless the result register is held
  assign ex_adv    = ex_valid && !(res_valid && res_stall);
  assign cmd_stall = ex_valid && res_valid && res_stall;
  assign cmd_xfer  = cmd_valid && !cmd_stall;

  mrexu_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (cmd_xfer),
    .rd_addr_a (cmd.instr_word[25:21]),
    .rd_addr_b (cmd.instr_word[20:16]),
    .rd_data_a (op_a),
    .rd_data_b (op_b),
    .wr_en     (ex_adv && exec.reg_we),
    .wr_addr   (exec.item.dest_index),
    .wr_data   (exec.item.write_value)
  );

  mrexu_alu u_alu (
    .cmd  (ex_cmd),
    .a    (op_a),
    .b    (op_b),
    .hi   (hi_reg),
    .lo   (lo_reg),
    .exec (exec)
  );

  // Execute stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (cmd_xfer) begin
      ex_valid <= 1'b1;
    end else if (ex_adv) begin
      ex_valid <= 1'b0;
    end
  end

  // Hold the command while it executes
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      ex_cmd <= cmd;
    end
  end

  // HI and LO updates
  always_ff @(posedge clk) begin
    if (rst) begin
      hi_reg <= '0;
      lo_reg <= '0;
    end else if (ex_adv) begin
      if (exec.hi_we) begin
        hi_reg <= op_a;
      end
      if (exec.lo_we) begin
        lo_reg <= op_a;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ex_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      res <= exec.item;
    end
  end

  // Checks
  `MRXU_ASSERT(a_adv_fills_res, clk, rst, ex_adv |=> res_valid,
               "execute result not registered")
  `MRXU_ASSERT(a_held_ex, clk, rst, cmd_stall |=> ex_valid,
               "held execute stage lost its command")
  `MRXU_ASSERT_NEVER(a_write_ok, clk, rst,
                     res_valid && res.wrote_reg && (res.status != ST_OK || res.dest_index == '0),
                     "register write reported with bad status or register zero")

endmodule

### test/testbench.sv
// Self-checking testbench for the R-type execute unit with a command-level predictor.
`timescale 1ns / 1ps

module testbench;
  import mrexu_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          NUM_ROWS     = 29;
  localparam int          NUM_BLOCKS   = 15;
  localparam int          BLOCK_ITEMS  = 50;
  localparam int          DRAIN_ITEM   = 375;
  localparam int          TAIL_CYCLES  = 8;
  localparam logic [5:0]  OPC_SPECIAL  = 6'd0;
  localparam logic [5:0]  OPC_FOREIGN  = 6'h3F;
  localparam logic [5:0]  FN_UNDEFINED = 6'd1;
  localparam logic [31:0] PC_DEFAULT   = 32'h0040_0000;
  localparam logic [31:0] PC_WRAP      = 32'hFFFF_FFF8;

  // Idle styles: none, long random gaps, short random gaps
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LONG  = 1;
  localparam int IDLE_SHORT = 2;

  localparam logic [5:0] VALID_FUNCTS [21] = '{
    FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
    FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
    FN_AND, FN_OR, FN_XOR, FN_SLT, FN_SLTU
  };

  typedef struct packed {
    logic fixed;
    res_t want;
  } pin_t;

  typedef struct {
    cmd_t stim;
    bit   pinned;
    res_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic res_valid;
  logic res_stall;
  res_t res;

  // Architectural state of the predictor
  logic [31:0] arch_gpr [32];
  logic [31:0] arch_hi;
  logic [31:0] arch_lo;

  res_t retire_q [$];
  pin_t pinned_q [$];
  int   err_count = 0;
  int   cycles = 0;
  int   tx_mode = IDLE_NONE;
  int   rx_mode = IDLE_NONE;
  row_t directed_rows [NUM_ROWS];

  mips_rtype_execute_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [31:0] rword(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh = 5'd0,
                                        logic [5:0] opc = OPC_SPECIAL);
    return {opc, rs, rt, rd, sh, op};
  endfunction

  function automatic cmd_t exec_cmd(logic [31:0] word, logic [31:0] pc = PC_DEFAULT);
    cmd_t c;
    c = '0;
    c.kind = KIND_EXEC;
    c.instr_word = word;
    c.pc_value = pc;
    return c;
  endfunction

  function automatic cmd_t load_cmd(logic [4:0] idx, logic [31:0] val);
    cmd_t c;
    c = '0;
    c.kind = KIND_LOAD;
    c.load_index = idx;
    c.load_value = val;
    return c;
  endfunction

  function automatic res_t outcome(logic [1:0] st, logic wr, logic [4:0] idx, logic [31:0] val,
                                   logic jt = 1'b0, logic [31:0] tgt = '0);
    res_t r;
    r.status = st;
    r.wrote_reg = wr;
    r.dest_index = idx;
    r.write_value = val;
    r.jump_taken = jt;
    r.jump_target = tgt;
    return r;
  endfunction

  function automatic row_t pinned_row(cmd_t c, res_t want);
    row_t r;
    r.stim = c;
    r.pinned = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic row_t free_row(cmd_t c);
    row_t r;
    r.stim = c;
    r.pinned = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // Execute one command against the predictor state and return its retire record
  function automatic res_t retire_cmd(cmd_t c);
    res_t        r;
    logic [31:0] w, a, b, v;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic        wr;
    r = '0;
    wr = 1'b0;
    widx = '0;
    v = '0;
    w = c.instr_word;
    if (c.kind == KIND_LOAD) begin
      wr = 1'b1;
      widx = c.load_index;
      v = c.load_value;
    end else begin
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      sh = w[10:6];
      a = (rs == 5'd0) ? '0 : arch_gpr[rs];
      b = (rt == 5'd0) ? '0 : arch_gpr[rt];
      widx = rd;
      if (w[31:26] != OPC_SPECIAL) begin
        r.status = ST_UNKNOWN;
      end else begin
        case (w[5:0])
          FN_ADD: begin
            v = a + b;
            if (a[31] == b[31] && v[31] != a[31]) r.status = ST_OVERFLOW;
            else wr = 1'b1;
          end
          FN_SUB: begin
            v = a - b;
            if (a[31] != b[31] && v[31] != a[31]) r.status = ST_OVERFLOW;
            else wr = 1'b1;
          end
          FN_ADDU: begin v = a + b; wr = 1'b1; end
          FN_SUBU: begin v = a - b; wr = 1'b1; end
          FN_AND:  begin v = a & b; wr = 1'b1; end
          FN_OR:   begin v = a | b; wr = 1'b1; end
          FN_XOR:  begin v = a ^ b; wr = 1'b1; end
          FN_SLL:  begin v = b << sh; wr = 1'b1; end
          FN_SRL:  begin v = b >> sh; wr = 1'b1; end
          FN_SRA:  begin v = $signed(b) >>> sh; wr = 1'b1; end
          FN_SLLV: begin v = b << a[4:0]; wr = 1'b1; end
          FN_SRLV: begin v = b >> a[4:0]; wr = 1'b1; end
          FN_SRAV: begin v = $signed(b) >>> a[4:0]; wr = 1'b1; end
          FN_SLT:  begin v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; wr = 1'b1; end
          FN_SLTU: begin v = (a < b) ? 32'd1 : 32'd0; wr = 1'b1; end
          FN_MFHI: begin v = arch_hi; wr = 1'b1; end
          FN_MFLO: begin v = arch_lo; wr = 1'b1; end
          FN_MTHI: arch_hi = a;
          FN_MTLO: arch_lo = a;
          FN_JR: begin
            r.jump_taken = 1'b1;
            r.jump_target = a;
          end
          FN_JALR: begin
            // target uses rs as read before the link lands
            r.jump_taken = 1'b1;
            r.jump_target = a;
            v = c.pc_value + LINK_OFFSET;
            wr = 1'b1;
          end
          default: r.status = ST_UNKNOWN;
        endcase
      end
    end
    // Drop writes to register zero
    if (wr && widx != 5'd0) begin
      arch_gpr[widx] = v;
      r.wrote_reg = 1'b1;
      r.dest_index = widx;
      r.write_value = v;
    end
    return r;
  endfunction

  function automatic int draw_gap(int mode);
    case (mode)
      IDLE_LONG:  return $urandom_range(0, 19);
      IDLE_SHORT: return $urandom_range(0, 2);
      default:    return 0;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Favor a few low registers so that results feed later operands
  function automatic logic [4:0] pick_reg();
    return $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t       c;
    logic [5:0] op, opc;
    c.kind = ($urandom_range(0, 3) == 0) ? KIND_LOAD : KIND_EXEC;
    c.pc_value = ($urandom_range(0, 15) == 0) ? PC_WRAP : 32'($urandom);
    c.load_index = 5'($urandom_range(0, 31));
    c.load_value = pick_value();
    op = ($urandom_range(0, 15) == 0) ? 6'($urandom) : VALID_FUNCTS[$urandom_range(0, 20)];
    opc = ($urandom_range(0, 31) == 0) ? 6'($urandom_range(1, 63)) : OPC_SPECIAL;
    c.instr_word = {opc, pick_reg(), pick_reg(), 5'($urandom), 5'($urandom), op};
    return c;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // Predict on each command transfer, check each result transfer
  always @(posedge clk) begin
    res_t pred, want;
    pin_t pin;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (retire_q.size() == 0) begin
          err_count++;
          $display("%0t: result %h with none outstanding", $time, res);
        end else begin
          want = retire_q.pop_front();
          check_field("status", 32'(want.status), 32'(res.status));
          check_field("wrote_reg", 32'(want.wrote_reg), 32'(res.wrote_reg));
          check_field("dest_index", 32'(want.dest_index), 32'(res.dest_index));
          check_field("write_value", want.write_value, res.write_value);
          check_field("jump_taken", 32'(want.jump_taken), 32'(res.jump_taken));
          check_field("jump_target", want.jump_target, res.jump_target);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        pred = retire_cmd(cmd);
        pin = pinned_q.pop_front();
        retire_q.push_back(pin.fixed ? pin.want : pred);
      end
    end
  end

  // Drive one command; entered and left at a falling edge
  task automatic send_cmd(cmd_t c, bit pinned, res_t want, bit drain);
    int   gap;
    pin_t pin;
    gap = draw_gap(tx_mode);
    if (drain || gap > 0) begin
      cmd_valid <= 1'b0;
      // hold off until every outstanding result has retired
      if (drain) begin
        do @(negedge clk); while (retire_q.size() != 0);
      end
      repeat (gap) @(negedge clk);
    end
    pin.fixed = pinned;
    pin.want = want;
    pinned_q.push_back(pin);
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  // Result side: stall a random stretch, then take one transfer
  initial begin
    int gap;
    res_stall = 1'b1;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = draw_gap(rx_mode);
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    foreach (arch_gpr[i]) arch_gpr[i] = '0;
    arch_hi = '0;
    arch_lo = '0;

    directed_rows = '{
      pinned_row(exec_cmd(rword(FN_ADD, 5'd1, 5'd2, 5'd3)), outcome(ST_OK, 1'b1, 5'd3, 32'd0)),
      pinned_row(load_cmd(5'd1, 32'h7FFF_FFFF), outcome(ST_OK, 1'b1, 5'd1, 32'h7FFF_FFFF)),
      pinned_row(load_cmd(5'd2, 32'h0000_0001), outcome(ST_OK, 1'b1, 5'd2, 32'h0000_0001)),
      pinned_row(load_cmd(5'd0, 32'hFFFF_FFFF), outcome(ST_OK, 1'b0, 5'd0, 32'd0)),
      pinned_row(load_cmd(5'd31, 32'h8000_0000), outcome(ST_OK, 1'b1, 5'd31, 32'h8000_0000)),
      pinned_row(exec_cmd(rword(FN_ADD, 5'd1, 5'd2, 5'd4)), outcome(ST_OVERFLOW, 1'b0, 5'd0, 32'd0)),
      pinned_row(exec_cmd(rword(FN_SUB, 5'd31, 5'd2, 5'd4)),
                 outcome(ST_OVERFLOW, 1'b0, 5'd0, 32'd0)),
      pinned_row(exec_cmd(rword(FN_ADDU, 5'd1, 5'd2, 5'd5)),
                 outcome(ST_OK, 1'b1, 5'd5, 32'h8000_0000)),
      pinned_row(exec_cmd(rword(FN_SUBU, 5'd31, 5'd2, 5'd6)),
                 outcome(ST_OK, 1'b1, 5'd6, 32'h7FFF_FFFF)),
      pinned_row(exec_cmd(rword(FN_ADD, 5'd1, 5'd1, 5'd7, 5'd0, OPC_FOREIGN)),
                 outcome(ST_UNKNOWN, 1'b0, 5'd0, 32'd0)),
      pinned_row(exec_cmd(rword(FN_UNDEFINED, 5'd1, 5'd2, 5'd7)),
                 outcome(ST_UNKNOWN, 1'b0, 5'd0, 32'd0)),
      free_row(exec_cmd(rword(FN_AND, 5'd1, 5'd31, 5'd7))),
      free_row(exec_cmd(rword(FN_OR, 5'd1, 5'd31, 5'd8))),
      free_row(exec_cmd(rword(FN_XOR, 5'd1, 5'd31, 5'd9))),
      free_row(exec_cmd(rword(FN_SLL, 5'd0, 5'd1, 5'd10, 5'd31))),
      free_row(exec_cmd(rword(FN_SRL, 5'd0, 5'd31, 5'd11, 5'd31))),
      free_row(exec_cmd(rword(FN_SRA, 5'd0, 5'd31, 5'd12, 5'd31))),
      // shift amount register with upper bits set; only the low five count
      pinned_row(load_cmd(5'd13, 32'hFFFF_FFE1), outcome(ST_OK, 1'b1, 5'd13, 32'hFFFF_FFE1)),
      free_row(exec_cmd(rword(FN_SLLV, 5'd13, 5'd1, 5'd14))),
      free_row(exec_cmd(rword(FN_SRLV, 5'd13, 5'd31, 5'd15))),
      free_row(exec_cmd(rword(FN_SRAV, 5'd13, 5'd31, 5'd16))),
      free_row(exec_cmd(rword(FN_SLT, 5'd31, 5'd1, 5'd17))),
      free_row(exec_cmd(rword(FN_SLTU, 5'd31, 5'd1, 5'd0))),
      pinned_row(exec_cmd(rword(FN_MTHI, 5'd1, 5'd0, 5'd0)), outcome(ST_OK, 1'b0, 5'd0, 32'd0)),
      pinned_row(exec_cmd(rword(FN_MTLO, 5'd31, 5'd0, 5'd0)), outcome(ST_OK, 1'b0, 5'd0, 32'd0)),
      free_row(exec_cmd(rword(FN_MFHI, 5'd0, 5'd0, 5'd19))),
      free_row(exec_cmd(rword(FN_MFLO, 5'd0, 5'd0, 5'd20))),
      pinned_row(exec_cmd(rword(FN_JR, 5'd31, 5'd0, 5'd0)),
                 outcome(ST_OK, 1'b0, 5'd0, 32'd0, 1'b1, 32'h8000_0000)),
      // link into the jump source register itself, with a wrapping link address
      free_row(exec_cmd(rword(FN_JALR, 5'd31, 5'd0, 5'd31), PC_WRAP))
    };

    // Hold reset over several rising edges, release at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    tx_mode = IDLE_SHORT;
    rx_mode = IDLE_SHORT;
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].want, 1'b0);

    // Random blocks, sweeping every pairing of idle styles
    n = 0;
    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      tx_mode = blk % 3;
      rx_mode = (blk / 3) % 3;
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        send_cmd(random_cmd(), 1'b0, '0, n == DRAIN_ITEM);
        n++;
      end
    end
    cmd_valid <= 1'b0;

    // Drain and let the pipe settle
    while (retire_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/mrexu_pkg.sv
design/mrexu_regfile.sv
design/mrexu_alu.sv
design/mips_rtype_execute_unit.sv
test/testbench.sv
